// ===== rtl/lpht_pkg.sv =====
`default_nettype none

package lpht_pkg;

  // fixed field widths
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned REC_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned SIZE_W   = 11;

  // table size after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  // quotient bits resolved per cycle by the modulo unit
  localparam int unsigned MOD_STEPS = 4;

  // operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_REPLACED  = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } lpht_status_e;

  // control sequence
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_CHECK,
    S_DONE
  } lpht_state_e;

  // one table entry as held in the slot memory
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] record_data;
  } lpht_entry_t;

endpackage

`default_nettype wire

// ===== rtl/lpht_if.sv =====
`default_nettype none

// request channel
interface lpht_in_if;
  import lpht_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [KEY_W-1:0] key;
  logic [REC_W-1:0] record_data;

  modport source (output valid, func, key, record_data, input ready);
  modport sink   (input valid, func, key, record_data, output ready);
endinterface

// result channel
interface lpht_out_if;
  import lpht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [REC_W-1:0]    found_data;

  modport source (output valid, status, slot, found_data, input ready);
  modport sink   (input valid, status, slot, found_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lpht_ram.sv =====
`default_nettype none

module lpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/lpht_mod.sv =====
`default_nettype none

module lpht_mod #(
  parameter int unsigned NW = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lpht_pkg::KEY_W-1:0] dividend_i,
  input  logic [NW-1:0]             divisor_i,
  output logic                      done_o,
  output logic [NW-1:0]             rem_o
);
  import lpht_pkg::*;

  localparam int unsigned NCyc = (KEY_W + MOD_STEPS - 1) / MOD_STEPS;
  localparam int unsigned PadW = NCyc * MOD_STEPS;
  localparam int unsigned CntW = (NCyc > 1) ? $clog2(NCyc) : 1;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PadW-1:0] sh_q, sh_d;
  logic [NW-1:0]   rem_q, rem_d;
  logic [NW-1:0]   div_q, div_d;
  logic [NW-1:0]   acc;
  logic [NW:0]     trial;

  // restoring remainder, several dividend bits per cycle
  always_comb begin
    acc = rem_q;
    for (int unsigned i = 0; i < MOD_STEPS; i++) begin
      trial = {acc, sh_q[PadW-1-i]};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      acc = trial[NW-1:0];
    end
  end

  // sequencing of the shared step
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = PadW'(dividend_i);
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = acc;
      sh_d  = sh_q << MOD_STEPS;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(NCyc - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
// channel   dir  handshake      payload
// cfg       in   cfg_we_i       cfg_wdata_i (table_size, 11 bits)
// req_i     in   valid/ready    func, key, record_data
// rsp_o     out  valid/ready    status, slot, found_data
//
// An item is accepted, then the modulo unit finds its home slot (four bits
// per cycle over the 31-bit key) and hands it over, then the slots are probed
// in turn through the registered read port of the slot memory, and finally
// the result register is loaded; no new item is taken before that.
// After reset a clearing pass writes every slot empty, during which
// req_i.ready is low; configuration writes are taken throughout.
// A result waiting on rsp_o holds the block in its last step until taken.
`default_nettype none

module linear_probe_hash_table #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lpht_pkg::SIZE_W-1:0] cfg_wdata_i,
  lpht_in_if.sink                     req_i,
  lpht_out_if.source                  rsp_o
);
  import lpht_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_SLOTS);
  localparam int unsigned NW   = AW + 1;
  localparam int unsigned EntW = $bits(lpht_entry_t);

  lpht_state_e         state_q, state_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic                func_q, func_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [REC_W-1:0]    data_q, data_d;
  logic [NW-1:0]       n_q, n_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [NW-1:0]       probes_q, probes_d;
  logic [AW-1:0]       clr_q, clr_d;
  lpht_status_e        res_status_q, res_status_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [REC_W-1:0]    res_found_q, res_found_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [REC_W-1:0]    out_found_q, out_found_d;

  logic [NW-1:0]       n_act;
  logic [AW-1:0]       pos_nxt;
  logic                accept;
  logic                mod_done;
  logic [NW-1:0]       mod_rem;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  lpht_entry_t         ram_wentry;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [EntW-1:0]     ram_rdata;
  lpht_entry_t         rd_entry;

  // active size: zero taken as one, clamped to the memory depth
  always_comb begin
    if (size_q == '0) begin
      n_act = NW'(1);
    end else if (32'(size_q) > MAX_SLOTS) begin
      n_act = NW'(MAX_SLOTS);
    end else begin
      n_act = NW'(size_q);
    end
  end

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // home slot
  lpht_mod #(
    .NW (NW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (req_i.key),
    .divisor_i  (n_act),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // slot memory: valid, key and record in one word
  lpht_ram #(
    .Width (EntW),
    .Depth (MAX_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = ram_rdata;

  // following slot with wrap at the active size
  assign pos_nxt = (NW'(pos_q) + NW'(1) == n_q) ? '0 : pos_q + AW'(1);

  // sequencer; the only write of an item comes in its last probe, and the
  // next item reads only after the modulo unit, so accesses never overlap
  always_comb begin
    state_d      = state_q;
    size_d       = cfg_we_i ? cfg_wdata_i : size_q;
    func_d       = func_q;
    key_d        = key_q;
    data_d       = data_q;
    n_d          = n_q;
    pos_d        = pos_q;
    probes_d     = probes_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_found_d  = out_found_q;
    ram_we       = 1'b0;
    ram_waddr    = pos_q;
    ram_wentry   = '{valid: 1'b1, key: key_q, record_data: data_q};
    ram_re       = 1'b0;
    ram_raddr    = pos_nxt;

    case (state_q)
      S_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_q;
        ram_wentry = '0;
        clr_d      = clr_q + AW'(1);
        if (clr_q == AW'(MAX_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          func_d  = req_i.func;
          key_d   = req_i.key;
          data_d  = req_i.record_data;
          n_d     = n_act;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(mod_rem);
          pos_d     = AW'(mod_rem);
          probes_d  = '0;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        // fetch the following slot ahead; dropped when the walk ends here
        ram_re      = 1'b1;
        res_found_d = '0;
        if (!rd_entry.valid) begin
          if (func_q == FUNC_INSERT) begin
            ram_we       = 1'b1;
            res_status_d = STAT_INSERTED;
            res_slot_d   = SLOT_W'(pos_q);
          end else begin
            res_status_d = STAT_NOT_FOUND;
            res_slot_d   = '0;
          end
          state_d = S_DONE;
        end else if (rd_entry.key == key_q) begin
          if (func_q == FUNC_SEARCH) begin
            res_status_d = STAT_FOUND;
            res_found_d  = rd_entry.record_data;
          end else begin
            ram_we       = 1'b1;
            res_status_d = STAT_REPLACED;
          end
          res_slot_d = SLOT_W'(pos_q);
          state_d    = S_DONE;
        end else if (probes_q == n_q - NW'(1)) begin
          res_status_d = (func_q == FUNC_SEARCH) ? STAT_NOT_FOUND : STAT_FULL;
          res_slot_d   = '0;
          state_d      = S_DONE;
        end else begin
          pos_d    = pos_nxt;
          probes_d = probes_q + NW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_found_d  = res_found_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      size_q      <= SIZE_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    data_q       <= data_d;
    n_q          <= n_d;
    pos_q        <= pos_d;
    probes_q     <= probes_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_found_q  <= out_found_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.slot       = out_slot_q;
  assign rsp_o.found_data = out_found_q;

endmodule

`default_nettype wire

// ===== rtl/lpht_checker.sv =====
`default_nettype none

module lpht_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [lpht_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [lpht_pkg::SLOT_W-1:0]   rsp_slot_i,
  input logic [lpht_pkg::REC_W-1:0]    rsp_found_data_i
);
  import lpht_pkg::*;

  // a stalled result transaction keeps its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_slot_i) && $stable(rsp_found_data_i))
    else $error("result changed while stalled");

  // one item in flight: no request taken right after another
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while an item is in flight");

  // only defined status codes leave the block
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i <= STAT_NOT_FOUND)
    else $error("undefined status code");

  // misses carry slot zero and no record
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == STAT_FULL || rsp_status_i == STAT_NOT_FOUND)
      |-> rsp_slot_i == '0 && rsp_found_data_i == '0)
    else $error("miss with non-zero slot or record");

  // insert results carry no record
  a_insert_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == STAT_INSERTED || rsp_status_i == STAT_REPLACED)
      |-> rsp_found_data_i == '0)
    else $error("insert result with non-zero record");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_slot_i       (rsp_o.slot),
  .rsp_found_data_i (rsp_o.found_data)
);

`default_nettype wire
